// ===== design/csv_line_field_splitter_macros.svh =====
// Assertion macros used by the checker file of the CSV line and field splitter.
`ifndef CSV_LINE_FIELD_SPLITTER_MACROS_SVH
`define CSV_LINE_FIELD_SPLITTER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CSVS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define CSVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== design/csvs_pkg.sv =====
// Package with the types, character codes and byte handling of the CSV splitter.
`timescale 1ns / 1ps

package csvs_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_END   = 8'hFF;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } src_item_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic       has_data;
        logic       ends_field;
        logic       ends_line;
        logic       ends_file;
        logic       last;
    } res_item_t;

    typedef struct packed {
        logic in_quote;
        logic field_open;
        logic content_seen;
        logic quote_pending;
        logic text_pending;
    } state_t;

    localparam state_t LINE_START = '{
        in_quote:      1'b0,
        field_open:    1'b1,
        content_seen:  1'b0,
        quote_pending: 1'b0,
        text_pending:  1'b0
    };

    typedef struct packed {
        logic      emit;
        res_item_t res;
        state_t    st;
    } byte_step_t;

    typedef struct packed {
        logic      v0;
        logic      v1;
        res_item_t r0;
        res_item_t r1;
    } push_t;

    function automatic res_item_t data_res(logic [7:0] c);
        res_item_t r;
        r          = '0;
        r.data_out = c;
        r.has_data = 1'b1;
        return r;
    endfunction

    function automatic res_item_t ctrl_res(logic ef, logic el, logic efile);
        res_item_t r;
        r            = '0;
        r.ends_field = ef;
        r.ends_line  = el;
        r.ends_file  = efile;
        return r;
    endfunction

    // Handles one byte outside the pending-quote decision.
    function automatic byte_step_t handle_byte(state_t st, logic [7:0] c);
        byte_step_t r;
        r.emit = 1'b0;
        r.res  = '0;
        r.st   = st;
        case (c)
            CH_QUOTE:
            begin
                if (st.in_quote)
                begin
                    r.st.quote_pending = 1'b1;
                end
                else
                begin
                    r.st.in_quote     = 1'b1;
                    r.st.content_seen = 1'b1;
                end
            end
            CH_COMMA:
            begin
                if (st.in_quote)
                begin
                    r.emit            = 1'b1;
                    r.res             = data_res(c);
                    r.st.content_seen = 1'b1;
                end
                else if (st.field_open)
                begin
                    r.emit = 1'b1;
                    r.res  = ctrl_res(1'b1, 1'b0, 1'b0);
                end
                else
                begin
                    r.st.field_open = 1'b1;
                end
            end
            CH_END:
            begin
                r.emit = 1'b1;
                r.res  = ctrl_res(1'b0, 1'b1, 1'b0);
                r.st   = LINE_START;
            end
            CH_CR:
            begin
                if (st.in_quote)
                begin
                    r.emit            = 1'b1;
                    r.res             = data_res(c);
                    r.st.content_seen = 1'b1;
                end
            end
            CH_LF:
            begin
                r.emit = 1'b1;
                if (st.in_quote)
                begin
                    r.res             = data_res(c);
                    r.st.content_seen = 1'b1;
                end
                else
                begin
                    r.res = ctrl_res(st.field_open, 1'b1, 1'b0);
                    r.st  = LINE_START;
                end
            end
            CH_SP, CH_TAB:
            begin
                if (st.content_seen)
                begin
                    r.emit = 1'b1;
                    r.res  = data_res(c);
                end
            end
            default:
            begin
                r.st.content_seen = 1'b1;
                if (st.field_open)
                begin
                    r.emit = 1'b1;
                    r.res  = data_res(c);
                end
            end
        endcase
        if (r.emit && r.res.has_data)
        begin
            r.st.text_pending = 1'b1;
        end
        if (r.emit && r.res.ends_field)
        begin
            r.st.text_pending = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== design/csvs_step.sv =====
// Parser state register and the per-byte decode that yields up to two results.
`timescale 1ns / 1ps

module csvs_step (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  csvs_pkg::src_item_t  item,
    output csvs_pkg::push_t      push
);

    csvs_pkg::state_t     state_reg;
    csvs_pkg::state_t     state_next;
    csvs_pkg::state_t     st_after_quote;
    csvs_pkg::byte_step_t hb;
    csvs_pkg::res_item_t  r0;
    csvs_pkg::res_item_t  r1;
    logic                 v0;
    logic                 v1;

    always_comb
    begin
        st_after_quote               = state_reg;
        st_after_quote.quote_pending = 1'b0;
        st_after_quote.text_pending  = 1'b0;
        st_after_quote.in_quote      = 1'b0;
        st_after_quote.field_open    = 1'b0;
        if (state_reg.quote_pending)
        begin
            hb = csvs_pkg::handle_byte(st_after_quote, item.data_byte);
        end
        else
        begin
            hb = csvs_pkg::handle_byte(state_reg, item.data_byte);
        end
    end

    always_comb
    begin
        v0         = 1'b0;
        v1         = 1'b0;
        r0         = '0;
        r1         = '0;
        state_next = state_reg;
        if (item.end_of_file)
        begin
            v0 = 1'b1;
            r0 = csvs_pkg::ctrl_res(!state_reg.quote_pending && state_reg.text_pending,
                                    1'b1, 1'b1);
            state_next = csvs_pkg::LINE_START;
        end
        else if (state_reg.quote_pending)
        begin
            v0 = 1'b1;
            if (item.data_byte == csvs_pkg::CH_QUOTE)
            begin
                r0                       = csvs_pkg::data_res(item.data_byte);
                state_next               = state_reg;
                state_next.quote_pending = 1'b0;
                state_next.text_pending  = 1'b1;
            end
            else
            begin
                r0         = csvs_pkg::ctrl_res(1'b1, 1'b0, 1'b0);
                v1         = hb.emit;
                r1         = hb.res;
                state_next = hb.st;
            end
        end
        else
        begin
            v0         = hb.emit;
            r0         = hb.res;
            state_next = hb.st;
        end
        r0.last = !v1;
        r1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csvs_pkg::LINE_START;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    assign push.v0 = fire && v0;
    assign push.v1 = fire && v0 && v1;
    assign push.r0 = r0;
    assign push.r1 = r1;

endmodule

// ===== design/csvs_outq.sv =====
// Result queue that takes up to two results per cycle and delivers one per cycle unless res_stall is high.
`timescale 1ns / 1ps

module csvs_outq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  csvs_pkg::push_t      push,
    output logic                 room,
    output logic                 res_valid,
    input  logic                 res_stall,
    output csvs_pkg::res_item_t  res_item
);

    csvs_pkg::res_item_t            mem_reg [csvs_pkg::QDEPTH];
    logic [csvs_pkg::QAW-1:0]       wr_ptr_reg;
    logic [csvs_pkg::QAW-1:0]       wr_ptr_next;
    logic [csvs_pkg::QAW-1:0]       wr_ptr_p1;
    logic [csvs_pkg::QAW-1:0]       rd_ptr_reg;
    logic [csvs_pkg::QAW-1:0]       rd_ptr_next;
    logic [csvs_pkg::QCW-1:0]       count_reg;
    logic [csvs_pkg::QCW-1:0]       count_next;
    logic                           pop;

    assign pop       = (count_reg != '0) && !res_stall;
    assign res_valid = (count_reg != '0);
    assign res_item  = mem_reg[rd_ptr_reg];
    assign room      = (count_reg <= csvs_pkg::QCW'(csvs_pkg::QDEPTH - 2));
    assign wr_ptr_p1 = wr_ptr_reg + csvs_pkg::QAW'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + csvs_pkg::QAW'(push.v0) + csvs_pkg::QAW'(push.v1);
        rd_ptr_next = rd_ptr_reg + csvs_pkg::QAW'(pop);
        count_next  = count_reg + csvs_pkg::QCW'(push.v0) + csvs_pkg::QCW'(push.v1)
                      - csvs_pkg::QCW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.v1)
        begin
            mem_reg[wr_ptr_p1] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/csv_line_field_splitter.sv =====
// Top level of the CSV line and field splitter.
`timescale 1ns / 1ps

// The splitter takes one file byte per transaction and returns markers for content bytes,
// field ends, line ends and the end of the file; a byte yields zero, one or two result
// transactions, and the last one of a byte has last set. A byte is accepted every cycle
// unless src_stall is high: it waits in the input register, its results are written into a
// four-entry result queue from there, and the queue hands out one result per cycle unless
// res_stall is high. A byte moves on from the input register only while the queue has room
// for two results, so a long run of bytes that each give two results is paced by the
// single result port.
module csv_line_field_splitter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_stall,
    input  csvs_pkg::src_item_t  src_item,
    output logic                 res_valid,
    input  logic                 res_stall,
    output csvs_pkg::res_item_t  res_item
);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    csvs_pkg::src_item_t  in_item_reg;
    logic                 room;
    logic                 fire;
    csvs_pkg::push_t      push;

    assign fire          = in_valid_reg && room;
    assign src_stall     = in_valid_reg && !room;
    assign in_valid_next = src_stall ? in_valid_reg : src_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && !src_stall)
        begin
            in_item_reg <= src_item;
        end
    end

    csvs_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_item_reg),
        .push  (push)
    );

    csvs_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule

// ===== design/csvs_checker.sv =====
// Port-level checker for the CSV line and field splitter, bound to the top level.
`timescale 1ns / 1ps
`include "csv_line_field_splitter_macros.svh"

module csvs_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 src_valid,
    input logic                 src_stall,
    input csvs_pkg::src_item_t  src_item,
    input logic                 res_valid,
    input logic                 res_stall,
    input csvs_pkg::res_item_t  res_item
);

    // A stalled source transaction stays offered and unchanged.
    `CSVS_ASSERT_NEXT(a_src_hold, clk, rst_n, src_valid && src_stall, src_valid && $stable(src_item))

    // A stalled result transaction stays offered and unchanged.
    `CSVS_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && res_stall, res_valid && $stable(res_item))

    // A result without a content byte carries a zero byte.
    `CSVS_ASSERT_NOW(a_data_zero, clk, rst_n, res_valid && !res_item.has_data, res_item.data_out == 8'h00)

    // The end of the file also ends the line and is the final result of its byte.
    `CSVS_ASSERT_NOW(a_eof_ends, clk, rst_n, res_valid && res_item.ends_file, res_item.ends_line && res_item.last)

    // A content byte never shares its result with a field, line or file end.
    `CSVS_ASSERT_NOW(a_data_alone, clk, rst_n, res_valid && res_item.has_data, !res_item.ends_field && !res_item.ends_line && !res_item.ends_file)

endmodule

bind csv_line_field_splitter csvs_checker u_chk (.*);

// ===== verif/tb.sv =====
// Testbench for the CSV line and field splitter, with a built-in marker predictor.
`timescale 1ns / 1ps

module tb;

    localparam int PERIOD_NS    = 12;
    localparam int RESET_CYCLES = 7;
    localparam int RECORD_ITEMS = 1250;
    localparam int TOTAL_ITEMS  = 1550;
    localparam int SETTLE_CYCLES = 16;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                src_valid = 1'b0;
    logic                src_stall;
    csvs_pkg::src_item_t src_item  = '0;
    logic                res_valid;
    logic                res_stall = 1'b0;
    csvs_pkg::res_item_t res_item;

    csvs_pkg::res_item_t expected_markers [$];
    int        mismatch_count = 0;
    int        sent_items     = 0;
    int        res_hold       = 0;
    bit        src_lazy       = 1'b1;
    bit        res_lazy       = 1'b1;

    logic in_q;
    logic fld_open;
    logic seen;
    logic q_pend;
    logic txt_pend;
    int   n_emit;

    csv_line_field_splitter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    initial
    begin
        forever #(PERIOD_NS / 2) clk = ~clk;
    end

    task automatic restart_line();
        in_q     = 1'b0;
        fld_open = 1'b1;
        seen     = 1'b0;
        q_pend   = 1'b0;
        txt_pend = 1'b0;
    endtask

    task automatic emit_marker(input logic [7:0] d, input logic hd, input logic ef,
                               input logic el, input logic efile);
        csvs_pkg::res_item_t m;
        m            = '0;
        m.data_out   = hd ? d : 8'h00;
        m.has_data   = hd;
        m.ends_field = ef;
        m.ends_line  = el;
        m.ends_file  = efile;
        expected_markers = {expected_markers, m};
        n_emit++;
        if (hd)
        begin
            txt_pend = 1'b1;
        end
        if (ef)
        begin
            txt_pend = 1'b0;
        end
    endtask

    task automatic scan_char(input logic [7:0] c);
        case (c)
            csvs_pkg::CH_QUOTE:
            begin
                if (in_q)
                begin
                    q_pend = 1'b1;
                end
                else
                begin
                    in_q = 1'b1;
                    seen = 1'b1;
                end
            end
            csvs_pkg::CH_COMMA:
            begin
                if (in_q)
                begin
                    emit_marker(c, 1'b1, 1'b0, 1'b0, 1'b0);
                    seen = 1'b1;
                end
                else if (fld_open)
                begin
                    emit_marker(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
                end
                else
                begin
                    fld_open = 1'b1;
                end
            end
            csvs_pkg::CH_END:
            begin
                emit_marker(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
                restart_line();
            end
            csvs_pkg::CH_CR:
            begin
                if (in_q)
                begin
                    emit_marker(c, 1'b1, 1'b0, 1'b0, 1'b0);
                    seen = 1'b1;
                end
            end
            csvs_pkg::CH_LF:
            begin
                if (in_q)
                begin
                    emit_marker(c, 1'b1, 1'b0, 1'b0, 1'b0);
                    seen = 1'b1;
                end
                else
                begin
                    emit_marker(8'h00, 1'b0, fld_open, 1'b1, 1'b0);
                    restart_line();
                end
            end
            csvs_pkg::CH_SP, csvs_pkg::CH_TAB:
            begin
                if (seen)
                begin
                    emit_marker(c, 1'b1, 1'b0, 1'b0, 1'b0);
                end
            end
            default:
            begin
                seen = 1'b1;
                if (fld_open)
                begin
                    emit_marker(c, 1'b1, 1'b0, 1'b0, 1'b0);
                end
            end
        endcase
    endtask

    task automatic predict_markers(input logic [7:0] c, input logic eof);
        n_emit = 0;
        if (eof)
        begin
            emit_marker(8'h00, 1'b0, q_pend ? 1'b0 : txt_pend, 1'b1, 1'b1);
            restart_line();
        end
        else if (q_pend)
        begin
            q_pend = 1'b0;
            if (c == csvs_pkg::CH_QUOTE)
            begin
                emit_marker(c, 1'b1, 1'b0, 1'b0, 1'b0);
            end
            else
            begin
                emit_marker(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
                in_q     = 1'b0;
                fld_open = 1'b0;
                scan_char(c);
            end
        end
        else
        begin
            scan_char(c);
        end
        if (n_emit > 0)
        begin
            expected_markers[expected_markers.size() - 1].last = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eof);
        int gap;
        gap = src_lazy ? $urandom_range(0, 9) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        src_item  <= '{data_byte: b, end_of_file: eof};
        src_valid <= 1'b1;
        @(posedge clk);
        while (src_stall) @(posedge clk);
        predict_markers(b, eof);
        sent_items++;
    endtask

    task automatic release_src();
        @(negedge clk);
        src_valid <= 1'b0;
    endtask

    task automatic drain_markers();
        release_src();
        while (expected_markers.size() != 0) @(posedge clk);
    endtask

    task automatic redraw_idling();
        src_lazy = $urandom_range(0, 3) != 0;
        res_lazy = $urandom_range(0, 3) != 0;
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do
        begin
            b = 8'($urandom_range(33, 254));
        end
        while (b == csvs_pkg::CH_QUOTE || b == csvs_pkg::CH_COMMA);
        return b;
    endfunction

    task automatic test_directed();
        logic [8:0] script [$] = {
            {1'b0, csvs_pkg::CH_SP}, {1'b0, csvs_pkg::CH_TAB}, {1'b0, 8'h61},
            {1'b0, csvs_pkg::CH_SP}, {1'b0, csvs_pkg::CH_COMMA},
            {1'b0, csvs_pkg::CH_QUOTE}, {1'b0, csvs_pkg::CH_COMMA},
            {1'b0, csvs_pkg::CH_CR}, {1'b0, csvs_pkg::CH_LF},
            {1'b0, csvs_pkg::CH_QUOTE}, {1'b0, csvs_pkg::CH_QUOTE},
            {1'b0, csvs_pkg::CH_QUOTE}, {1'b0, 8'h7A},
            {1'b0, csvs_pkg::CH_SP}, {1'b0, csvs_pkg::CH_COMMA},
            {1'b0, csvs_pkg::CH_CR}, {1'b0, csvs_pkg::CH_COMMA},
            {1'b0, 8'h00}, {1'b0, csvs_pkg::CH_QUOTE}, {1'b0, csvs_pkg::CH_END},
            {1'b0, 8'h71}, {1'b1, csvs_pkg::CH_END}, {1'b0, csvs_pkg::CH_QUOTE},
            {1'b0, 8'h6B}, {1'b0, csvs_pkg::CH_QUOTE},
            {1'b1, 8'h00}, {1'b0, 8'hFE}, {1'b0, csvs_pkg::CH_QUOTE},
            {1'b0, csvs_pkg::CH_QUOTE}, {1'b0, csvs_pkg::CH_LF}, {1'b1, 8'h80}
        };
        foreach (script[i])
        begin
            send_byte(script[i][7:0], script[i][8]);
        end
    endtask

    task automatic test_random_records();
        int lines;
        int nfields;
        lines = 0;
        while (sent_items < RECORD_ITEMS)
        begin
            lines++;
            if (lines % 8 == 0)
            begin
                redraw_idling();
            end
            if (lines == 40)
            begin
                drain_markers();
            end
            nfields = $urandom_range(1, 5);
            for (int f = 0; f < nfields; f++)
            begin
                if (f > 0)
                begin
                    send_byte(csvs_pkg::CH_COMMA, 1'b0);
                end
                repeat ($urandom_range(0, 2))
                    send_byte($urandom_range(0, 1) ? csvs_pkg::CH_SP : csvs_pkg::CH_TAB, 1'b0);
                if ($urandom_range(0, 2) == 0)
                begin
                    send_byte(csvs_pkg::CH_QUOTE, 1'b0);
                    repeat ($urandom_range(0, 6))
                    begin
                        case ($urandom_range(0, 7))
                            0:
                            begin
                                send_byte(csvs_pkg::CH_QUOTE, 1'b0);
                                send_byte(csvs_pkg::CH_QUOTE, 1'b0);
                            end
                            1:       send_byte(csvs_pkg::CH_COMMA, 1'b0);
                            2:
                                send_byte($urandom_range(0, 1) ? csvs_pkg::CH_CR
                                                               : csvs_pkg::CH_LF, 1'b0);
                            default: send_byte(text_byte(), 1'b0);
                        endcase
                    end
                    send_byte(csvs_pkg::CH_QUOTE, 1'b0);
                    repeat ($urandom_range(0, 1)) send_byte(csvs_pkg::CH_SP, 1'b0);
                end
                else
                begin
                    repeat ($urandom_range(0, 6)) send_byte(text_byte(), 1'b0);
                end
                if ($urandom_range(0, 19) == 0)
                begin
                    send_byte(8'($urandom), 1'b0);
                end
            end
            case ($urandom_range(0, 19))
                0:          send_byte(csvs_pkg::CH_END, 1'b0);
                1:          send_byte(8'($urandom), 1'b1);
                2, 3, 4, 5:
                begin
                    send_byte(csvs_pkg::CH_CR, 1'b0);
                    send_byte(csvs_pkg::CH_LF, 1'b0);
                end
                default:    send_byte(csvs_pkg::CH_LF, 1'b0);
            endcase
        end
    endtask

    task automatic test_random_noise();
        logic [7:0] specials [7] = '{csvs_pkg::CH_QUOTE, csvs_pkg::CH_COMMA, csvs_pkg::CH_CR,
                                     csvs_pkg::CH_LF, csvs_pkg::CH_SP, csvs_pkg::CH_TAB,
                                     csvs_pkg::CH_END};
        while (sent_items < TOTAL_ITEMS)
        begin
            if (sent_items % 50 == 0)
            begin
                redraw_idling();
            end
            case ($urandom_range(0, 9))
                0:          send_byte(8'($urandom), 1'b1);
                1, 2, 3, 4: send_byte(specials[$urandom_range(0, 6)], 1'b0);
                default:    send_byte(8'($urandom), 1'b0);
            endcase
        end
    endtask

    always @(negedge clk)
    begin
        if (res_hold > 0)
        begin
            res_stall <= 1'b1;
            res_hold--;
        end
        else
        begin
            res_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        csvs_pkg::res_item_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            res_hold = res_lazy ? $urandom_range(0, 9) : 0;
            if (expected_markers.size() == 0)
            begin
                report_mismatch("unexpected transaction", int'(res_item), 0);
            end
            else
            begin
                want = expected_markers.pop_front();
                if (res_item.data_out !== want.data_out)
                    report_mismatch("data_out", int'(res_item.data_out), int'(want.data_out));
                if (res_item.has_data !== want.has_data)
                    report_mismatch("has_data", int'(res_item.has_data), int'(want.has_data));
                if (res_item.ends_field !== want.ends_field)
                    report_mismatch("ends_field", int'(res_item.ends_field),
                                    int'(want.ends_field));
                if (res_item.ends_line !== want.ends_line)
                    report_mismatch("ends_line", int'(res_item.ends_line), int'(want.ends_line));
                if (res_item.ends_file !== want.ends_file)
                    report_mismatch("ends_file", int'(res_item.ends_file), int'(want.ends_file));
                if (res_item.last !== want.last)
                    report_mismatch("last", int'(res_item.last), int'(want.last));
            end
        end
    end

    initial
    begin
        restart_line();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        drain_markers();
        test_random_records();
        drain_markers();
        test_random_noise();
        drain_markers();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
